// File: src/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the lru frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

    localparam int FRAME_W = 6;   // width of the frame field
    localparam int CNT_W   = 7;   // width of the occupancy count

    localparam logic [1:0] CMD_TOUCH  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_VICTIM = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UNLINK,
        S_PUSH1,
        S_PUSH2
    } t_state;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim_frame;
        logic [CNT_W-1:0]   occupancy;
    } t_result;

endpackage

`default_nettype wire

// File: src/lfr_ram.sv
// ----------------------------------------------------------------------------
// lfr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/lfr_engine.sv
// ----------------------------------------------------------------------------
// lfr_engine
// list sequencer: unlinks and relinks frames in the two link memories
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_engine #(
    parameter int FRAMES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_frame,
    input  wire logic                        i_slot_free,
    output logic                             o_idle,
    output logic                             o_res_valid,
    output lfr_pkg::t_result                 o_res
);

    localparam int IW  = $clog2(FRAMES);
    localparam int MAXF = 1 << lfr_pkg::FRAME_W;
    localparam int NP  = (FRAMES < MAXF) ? FRAMES : MAXF;
    localparam int PW  = (NP > 1) ? $clog2(NP) : 1;

    localparam int CW = lfr_pkg::CNT_W;

    lfr_pkg::t_state r_state, n_state;

    logic [1:0]    r_cmd, n_cmd;
    logic [IW-1:0] r_f, n_f;
    logic          r_act, n_act;
    logic          r_touch, n_touch;
    logic [IW-1:0] r_newest, n_newest;
    logic [IW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_count, n_count;
    logic          r_present [NP];
    logic          n_present [NP];

    // link memory ports
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] rd_older, rd_newer;
    logic          wo_en, wn_en;
    logic [IW-1:0] wo_addr, wo_data, wn_addr, wn_data;

    lfr_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_older (
        .i_clk   (i_clk),
        .i_we    (wo_en),
        .i_waddr (wo_addr),
        .i_wdata (wo_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_older)
    );

    lfr_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_newer (
        .i_clk   (i_clk),
        .i_we    (wn_en),
        .i_waddr (wn_addr),
        .i_wdata (wn_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_newer)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lfr_pkg::S_IDLE;
            r_newest  <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_present <= '{default: 1'b0};
        end else begin
            r_state   <= n_state;
            r_newest  <= n_newest;
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_present <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_f     <= n_f;
        r_act   <= n_act;
        r_touch <= n_touch;
    end

    always_comb begin
        logic [IW-1:0] f_in;
        logic          in_range;
        logic          hit;
        logic          last;

        n_state   = r_state;
        n_cmd     = r_cmd;
        n_f       = r_f;
        n_act     = r_act;
        n_touch   = r_touch;
        n_newest  = r_newest;
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_present = r_present;

        rd_en   = 1'b0;
        rd_addr = r_oldest;
        wo_en   = 1'b0;
        wo_addr = r_f;
        wo_data = r_f;
        wn_en   = 1'b0;
        wn_addr = r_f;
        wn_data = r_f;

        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        f_in     = IW'(i_frame);
        in_range = 32'(i_frame) < 32'(FRAMES);
        hit      = in_range && r_present[PW'(f_in)];
        last     = !r_touch;

        case (r_state)
            lfr_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    rd_en   = 1'b1;
                    rd_addr = (i_cmd == lfr_pkg::CMD_VICTIM) ? r_oldest : f_in;
                    n_cmd   = i_cmd;
                    n_f     = (i_cmd == lfr_pkg::CMD_VICTIM) ? r_oldest : f_in;
                    n_touch = (i_cmd == lfr_pkg::CMD_TOUCH) && in_range;
                    case (i_cmd)
                        lfr_pkg::CMD_TOUCH:  n_act = hit;
                        lfr_pkg::CMD_REMOVE: n_act = hit;
                        lfr_pkg::CMD_VICTIM: n_act = (r_count != '0);
                        default:             n_act = 1'b0;
                    endcase
                    if ((i_cmd == lfr_pkg::CMD_TOUCH) && in_range && !hit) begin
                        n_state = lfr_pkg::S_PUSH1;
                    end else begin
                        n_state = lfr_pkg::S_UNLINK;
                    end
                end
            end

            lfr_pkg::S_UNLINK: begin
                if (!last || i_slot_free) begin
                    if (r_act) begin
                        if (r_count <= CW'(1)) begin
                            n_newest = '0;
                            n_oldest = '0;
                        end else if (r_f == r_newest) begin
                            n_newest = rd_older;
                            wn_en    = 1'b1;
                            wn_addr  = rd_older;
                            wn_data  = rd_older;
                        end else if (r_f == r_oldest) begin
                            n_oldest = rd_newer;
                            wo_en    = 1'b1;
                            wo_addr  = rd_newer;
                            wo_data  = rd_newer;
                        end else begin
                            wo_en   = 1'b1;
                            wo_addr = rd_newer;
                            wo_data = rd_older;
                            wn_en   = 1'b1;
                            wn_addr = rd_older;
                            wn_data = rd_newer;
                        end
                        n_present[PW'(r_f)] = 1'b0;
                        n_count = r_count - CW'(1);
                    end
                    if (last) begin
                        o_res_valid        = 1'b1;
                        o_res.found        = r_act;
                        o_res.victim_frame = (r_cmd == lfr_pkg::CMD_VICTIM && r_act)
                                           ? lfr_pkg::FRAME_W'(r_f) : '0;
                        o_res.occupancy    = n_count;
                        n_state            = lfr_pkg::S_IDLE;
                    end else begin
                        n_state = lfr_pkg::S_PUSH1;
                    end
                end
            end

            lfr_pkg::S_PUSH1: begin
                // link the frame behind the current newest
                wo_en   = 1'b1;
                wo_addr = r_f;
                wo_data = (r_count == '0) ? r_f : r_newest;
                if (r_count != '0) begin
                    wn_en   = 1'b1;
                    wn_addr = r_newest;
                    wn_data = r_f;
                end
                n_state = lfr_pkg::S_PUSH2;
            end

            lfr_pkg::S_PUSH2: begin
                if (i_slot_free) begin
                    wn_en    = 1'b1;
                    wn_addr  = r_f;
                    wn_data  = r_f;
                    n_newest = r_f;
                    if (r_count == '0) begin
                        n_oldest = r_f;
                    end
                    n_present[PW'(r_f)] = 1'b1;
                    n_count             = r_count + CW'(1);
                    o_res_valid         = 1'b1;
                    o_res.found         = 1'b1;
                    o_res.victim_frame  = '0;
                    o_res.occupancy     = n_count;
                    n_state             = lfr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lfr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_core
// least-recently-used replacer for buffer frames, list held in link memories
// ----------------------------------------------------------------------------
//
//  channel   valid         ready         payload
//  -------   -----------   -----------   ----------------------------------
//  input     i_in_valid    o_in_ready    i_cmd, i_frame
//  output    o_out_valid   i_out_ready   o_found, o_victim_frame, o_occupancy
//
//  steps per transaction, from acceptance back to idle:
//    remove, victim, ignored commands: link read, then unlink write-back
//    touch of an absent frame: link read, then relink writes in PUSH1 and PUSH2
//    touch of a present frame: read, unlink, then relink writes in PUSH1 and PUSH2
//  the steps are set by the one write port of each link memory
//  reset is synchronous; the list comes up empty, no memory clearing pass
//  the final step of a transaction waits while the output register is full
//  and not being taken; a new input is accepted while a result waits
//
`default_nettype none

module lru_frame_replacer_core #(
    parameter int FRAMES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_frame,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_found,
    output logic      [lfr_pkg::FRAME_W-1:0] o_victim_frame,
    output logic      [lfr_pkg::CNT_W-1:0]   o_occupancy
);

    logic             eng_idle;
    logic             res_valid;
    logic             slot_free;
    lfr_pkg::t_result res;

    // output register state
    logic             r_out_valid;
    lfr_pkg::t_result r_out;

    // the output slot is free when empty or being drained this cycle
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = eng_idle;

    lfr_engine #(.FRAMES(FRAMES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && eng_idle),
        .i_cmd       (i_cmd),
        .i_frame     (i_frame),
        .i_slot_free (slot_free),
        .o_idle      (eng_idle),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register, loaded only when the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out.found;
    assign o_victim_frame = r_out.victim_frame;
    assign o_occupancy    = r_out.occupancy;

endmodule

`default_nettype wire

// File: src/lfr_checker.sv
// ----------------------------------------------------------------------------
// lfr_checker
// port-level checks of the lru frame replacer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        o_found,
    input wire logic [lfr_pkg::FRAME_W-1:0] o_victim_frame,
    input wire logic [lfr_pkg::CNT_W-1:0]   o_occupancy
);

    // occupancy never exceeds the reachable frame range
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= lfr_pkg::CNT_W'(64)))
        else $error("occupancy out of range");

    // a nonzero victim frame only comes with found
    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_victim_frame != '0)) |-> o_found)
        else $error("victim frame without found");

    // one transaction at a time: ready drops right after acceptance
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found) && $stable(o_victim_frame)
             && $stable(o_occupancy)))
        else $error("stalled result changed");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind lru_frame_replacer_core lfr_checker u_lfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_victim_frame (o_victim_frame),
    .o_occupancy    (o_occupancy)
);

`default_nettype wire

// File: tb/lru_order_checker.sv
// ----------------------------------------------------------------------------
// lru_order_checker
// watches both channels of the lru frame replacer, keeps its own recency
// order of the evictable frames, and checks every result against it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_order_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_frame,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        i_found,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_victim_frame,
    input  wire logic [lfr_pkg::CNT_W-1:0]   i_occupancy,
    output int                               o_fail_count,
    output int                               o_pending
);

    // index 0 holds the least recently used frame
    logic [lfr_pkg::FRAME_W-1:0] lru_order[$];
    lfr_pkg::t_result            due_results[$];
    lfr_pkg::t_result            want;
    int                          fail_cnt = 0;

    task automatic report_mismatch(input string field, input int got, input int wanted);
        $display("%0t: %s mismatch, got %0d, want %0d", $time, field, got, wanted);
        fail_cnt++;
    endtask

    function automatic lfr_pkg::t_result lru_apply(
        input logic [1:0]                  op,
        input logic [lfr_pkg::FRAME_W-1:0] fr
    );
        lfr_pkg::t_result r;
        int               pos;
        r   = '0;
        pos = -1;
        for (int k = 0; k < lru_order.size(); k++) begin
            if (lru_order[k] == fr) pos = k;
        end
        case (op)
            lfr_pkg::CMD_TOUCH: begin
                if (pos >= 0) lru_order.delete(pos);
                lru_order.push_back(fr);
                r.found = 1'b1;
            end
            lfr_pkg::CMD_REMOVE: begin
                if (pos >= 0) begin
                    lru_order.delete(pos);
                    r.found = 1'b1;
                end
            end
            lfr_pkg::CMD_VICTIM: begin
                if (lru_order.size() > 0) begin
                    r.victim_frame = lru_order.pop_front();
                    r.found        = 1'b1;
                end
            end
            default: ;
        endcase
        r.occupancy = lfr_pkg::CNT_W'(lru_order.size());
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results are registered, so an output never answers the same edge's input
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result, occupancy", i_occupancy, 0);
                end else begin
                    want = due_results.pop_front();
                    if (i_found !== want.found)
                        report_mismatch("found", i_found, want.found);
                    if (i_victim_frame !== want.victim_frame)
                        report_mismatch("victim_frame", i_victim_frame, want.victim_frame);
                    if (i_occupancy !== want.occupancy)
                        report_mismatch("occupancy", i_occupancy, want.occupancy);
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(lru_apply(i_cmd, i_frame));
        end
        o_pending    <= due_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: tb/tb_lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// tb_lru_frame_replacer_core
// drives touch, remove and victim transactions into the lru frame replacer
// with random gaps and back-pressure; a checker beside the block predicts
// every result and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lru_frame_replacer_core;

    // the command encoding the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1400;
    localparam int HOLD_CYCLES = 300;     // receiver hold-off for the pressure phase
    localparam int TAIL_CYCLES = 20;      // settle time after the last result
    localparam int CYCLE_LIMIT = 400000;  // well above the slowest correct run

    // every block input has a known value from time zero
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic [1:0]                    i_cmd       = lfr_pkg::CMD_TOUCH;
    logic [lfr_pkg::FRAME_W-1:0]   i_frame     = '0;
    logic                          i_out_ready = 1'b0;
    wire                           o_in_ready;
    wire                           o_out_valid;
    wire                           o_found;
    wire  [lfr_pkg::FRAME_W-1:0]   o_victim_frame;
    wire  [lfr_pkg::CNT_W-1:0]     o_occupancy;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycle_cnt  = 0;

    // pacing controls, written with nonblocking assignments by the stimulus
    bit steady    = 1'b0;   // no idling on either side
    int hold_asks = 0;      // each increment asks the receiver for one hold-off

    // receiver-local bookkeeping
    int hold_seen = 0;
    int hold_left = 0;

    lru_frame_replacer_core #(
        .FRAMES         (64)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_frame        (i_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_occupancy    (o_occupancy)
    );

    lru_order_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_frame        (i_frame),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_found        (o_found),
        .i_victim_frame (o_victim_frame),
        .i_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_lru_frame_replacer_core failed");
            $finish;
        end
    end

    // receiver side: random stalls, a steady stretch, and on request a long
    // hold-off counted here so the block fills up and stalls its input
    always @(posedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 37);
        end
    end

    // one transaction on the input channel; valid is raised once per item and
    // only dropped during an idle gap, never lowered and raised in one step
    task automatic send_item(input logic [1:0] op, input logic [lfr_pkg::FRAME_W-1:0] fr);
        if (!steady) begin
            while ($urandom_range(99) < 37) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_cmd      <= op;
        i_frame    <= fr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // touch every frame in shuffled order to reach a full set, re-touch a few
    // while full, then take victims until empty and two beyond
    task automatic fill_and_drain();
        int perm [64];
        int j;
        int t;
        for (int k = 0; k < 64; k++) perm[k] = k;
        for (int k = 63; k > 0; k--) begin
            j       = $urandom_range(k);
            t       = perm[k];
            perm[k] = perm[j];
            perm[j] = t;
        end
        for (int k = 0; k < 64; k++)
            send_item(lfr_pkg::CMD_TOUCH, lfr_pkg::FRAME_W'(perm[k]));
        repeat ($urandom_range(4, 12))
            send_item(lfr_pkg::CMD_TOUCH, lfr_pkg::FRAME_W'($urandom_range(63)));
        repeat (66)
            send_item(lfr_pkg::CMD_VICTIM, lfr_pkg::FRAME_W'($urandom_range(63)));
    endtask

    // a burst of mixed commands; a narrow frame window makes touches and
    // removes hit frames already in the set
    task automatic mixed_burst(input bit narrow);
        int         n;
        int         p;
        int         base;
        logic [1:0] op;
        n    = $urandom_range(8, 32);
        base = $urandom_range(56);
        repeat (n) begin
            p  = $urandom_range(99);
            op = (p < 45) ? lfr_pkg::CMD_TOUCH  :
                 (p < 65) ? lfr_pkg::CMD_REMOVE :
                 (p < 95) ? lfr_pkg::CMD_VICTIM : CMD_UNUSED;
            send_item(op, narrow ? lfr_pkg::FRAME_W'(base + $urandom_range(7))
                                 : lfr_pkg::FRAME_W'($urandom_range(63)));
        end
    endtask

    task automatic run_traffic(input int upto);
        int pick;
        while (items_sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 8)
                fill_and_drain();
            else if (pick < 70)
                mixed_burst(1'b1);
            else
                mixed_burst(1'b0);
        end
    endtask

    initial begin
        // synchronous reset held at the start, then released
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set cases and unused command
        send_item(lfr_pkg::CMD_VICTIM, 6'd0);
        send_item(lfr_pkg::CMD_REMOVE, 6'd63);
        send_item(CMD_UNUSED, 6'd63);
        // build 63, 42, 21 with 0 oldest; frames 21 and 42 cover every bit
        send_item(lfr_pkg::CMD_TOUCH, 6'd0);
        send_item(lfr_pkg::CMD_TOUCH, 6'd63);
        send_item(lfr_pkg::CMD_TOUCH, 6'd42);
        send_item(lfr_pkg::CMD_TOUCH, 6'd21);
        // touch of a present frame: oldest, then newest, then middle
        send_item(lfr_pkg::CMD_TOUCH, 6'd0);
        send_item(lfr_pkg::CMD_TOUCH, 6'd0);
        send_item(lfr_pkg::CMD_TOUCH, 6'd42);
        send_item(CMD_UNUSED, 6'd0);
        // removes from the middle, the newest end and the oldest end
        send_item(lfr_pkg::CMD_REMOVE, 6'd21);
        send_item(lfr_pkg::CMD_REMOVE, 6'd42);
        send_item(lfr_pkg::CMD_REMOVE, 6'd63);
        send_item(lfr_pkg::CMD_REMOVE, 6'd63);
        // single entry: touch it again, then take it as victim
        send_item(lfr_pkg::CMD_TOUCH, 6'd0);
        send_item(lfr_pkg::CMD_VICTIM, 6'd63);
        send_item(lfr_pkg::CMD_VICTIM, 6'd0);
        send_item(lfr_pkg::CMD_TOUCH, 6'd5);
        send_item(lfr_pkg::CMD_REMOVE, 6'd5);
        // victims come out oldest first
        send_item(lfr_pkg::CMD_TOUCH, 6'd7);
        send_item(lfr_pkg::CMD_TOUCH, 6'd9);
        send_item(lfr_pkg::CMD_VICTIM, 6'd0);
        send_item(lfr_pkg::CMD_VICTIM, 6'd0);
        send_item(lfr_pkg::CMD_VICTIM, 6'd0);

        run_traffic(500);

        // long stretch with no idling, and a receiver hold-off on top of it
        steady    <= 1'b1;
        hold_asks <= hold_asks + 1;
        run_traffic(items_sent + 250);
        steady    <= 1'b0;

        run_traffic(ITEM_TARGET);

        // drain: the checker's pending count is registered, so it lags behind acceptance
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_lru_frame_replacer_core passed");
        else
            $display("tb_lru_frame_replacer_core failed");
        $finish;
    end

endmodule

// File: files.f
src/lfr_pkg.sv
src/lfr_ram.sv
src/lfr_engine.sv
src/lru_frame_replacer_core.sv
src/lfr_checker.sv
tb/lru_order_checker.sv
tb/tb_lru_frame_replacer_core.sv
